>>> src/ptab_pkg.sv
`timescale 1ns / 1ps
package ptab_pkg;

  localparam int unsigned ReqTypeW = 4;
  localparam int unsigned IndexW   = 6;
  localparam int unsigned ValueW   = 6;
  localparam int unsigned AmountW  = 32;
  localparam int unsigned CfgW     = 7;
  localparam int unsigned RegionW  = 3;
  localparam int unsigned NumRegions = 5;

  localparam logic [ReqTypeW-1:0] OP_READ     = 4'd0;
  localparam logic [ReqTypeW-1:0] OP_WR_WORK  = 4'd1;
  localparam logic [ReqTypeW-1:0] OP_WR_OPND  = 4'd2;
  localparam logic [ReqTypeW-1:0] OP_IDENTITY = 4'd3;
  localparam logic [ReqTypeW-1:0] OP_SWAP     = 4'd4;
  localparam logic [ReqTypeW-1:0] OP_ROT_UP   = 4'd5;
  localparam logic [ReqTypeW-1:0] OP_ROT_DOWN = 4'd6;
  localparam logic [ReqTypeW-1:0] OP_INVERT   = 4'd7;
  localparam logic [ReqTypeW-1:0] OP_COMPOSE  = 4'd8;
  localparam logic [ReqTypeW-1:0] OP_POWER    = 4'd9;
  localparam logic [ReqTypeW-1:0] OP_CYCLES   = 4'd10;
  localparam logic [ReqTypeW-1:0] OP_INIT     = 4'd15;

  localparam logic [RegionW-1:0] RG_WORK    = 3'd0;
  localparam logic [RegionW-1:0] RG_OPND    = 3'd1;
  localparam logic [RegionW-1:0] RG_BASE    = 3'd2;
  localparam logic [RegionW-1:0] RG_ACCUM   = 3'd3;
  localparam logic [RegionW-1:0] RG_SCRATCH = 3'd4;

  typedef enum logic [2:0] {
    PS_FILL,
    PS_COPY,
    PS_COMP,
    PS_ROT,
    PS_INV
  } pass_e;

endpackage

>>> src/ptab_req_if.sv
`timescale 1ns / 1ps
interface ptab_req_if;
  import ptab_pkg::*;
  logic                valid;
  logic                ready;
  logic [ReqTypeW-1:0] req_type;
  logic [IndexW-1:0]   index_a;
  logic [IndexW-1:0]   index_b;
  logic [ValueW-1:0]   entry_value;
  logic [AmountW-1:0]  amount;
  modport source (output valid, req_type, index_a, index_b, entry_value, amount, input ready);
  modport sink (input valid, req_type, index_a, index_b, entry_value, amount, output ready);
endinterface

>>> src/ptab_rsp_if.sv
`timescale 1ns / 1ps
interface ptab_rsp_if;
  import ptab_pkg::*;
  logic              valid;
  logic              ready;
  logic [ValueW-1:0] result_value;
  logic              cycle_end;
  logic              last;
  logic [ValueW-1:0] transp_cnt;
  logic              status;
  modport source (output valid, result_value, cycle_end, last, transp_cnt, status,
                  input ready);
  modport sink (input valid, result_value, cycle_end, last, transp_cnt, status,
                output ready);
endinterface

>>> src/ptab_mod_unit.sv
`timescale 1ns / 1ps
module ptab_mod_unit #(
  parameter int unsigned DW = 32,
  parameter int unsigned NW = 7
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  logic [DW-1:0] dividend_i,
  input  logic [NW-1:0] divisor_i,
  output logic          busy_o,
  output logic [NW-1:0] rem_o
);
  localparam int unsigned CW = $clog2(DW + 1);

  logic          busy_q;
  logic [CW-1:0] cnt_q;
  logic [DW-1:0] sh_q;
  logic [NW-1:0] rem_q;
  logic [NW:0]   trial;
  logic [NW:0]   reduced;

  assign trial   = {rem_q, sh_q[DW-1]};
  assign reduced = (trial >= {1'b0, divisor_i}) ? trial - {1'b0, divisor_i} : trial;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      cnt_q  <= CW'(DW);
    end else if (busy_q) begin
      cnt_q <= cnt_q - CW'(1);
      if (cnt_q == CW'(1)) begin
        busy_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      sh_q  <= dividend_i;
      rem_q <= '0;
    end else if (busy_q) begin
      sh_q  <= sh_q << 1;
      rem_q <= reduced[NW-1:0];
    end
  end

  assign busy_o = busy_q;
  assign rem_o  = rem_q;
endmodule

>>> src/permutation_table_engine_unit.sv
`timescale 1ns / 1ps
// Permutation table engine. Holds a working and an operand permutation in one
// single-port-read, single-port-write table memory (with base, accumulator and
// scratch regions), and runs one request at a time. Swap reads both entries and
// then writes them back crossed. Whole-table requests walk the entries through
// the memory (read, residue lookup, dependent read, write), and compose, invert
// and rotate end in a copy-back pass from the scratch region. Rotate first runs
// the residue divider on the amount; power copies the base, fills the
// accumulator with the identity, and then composes and copies back per set
// exponent bit and per squaring, plus a final copy. Cycle decomposition clears
// the visited flags and then walks each element, stalling whenever a result
// waits. After reset the working and operand regions are loaded with the
// identity, and after reset or any size_in_use write the residue table is
// rebuilt; no request is taken meanwhile.
module permutation_table_engine_unit #(
  parameter int unsigned MAX_ENTRIES = 64,
  parameter int unsigned AMOUNT_BITS = 32
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_we_i,
  input  logic [ptab_pkg::CfgW-1:0] cfg_wdata_i,
  ptab_req_if.sink                  req_i,
  ptab_rsp_if.source                rsp_o
);
  import ptab_pkg::*;

  localparam int unsigned IW    = $clog2(MAX_ENTRIES);
  localparam int unsigned NW    = $clog2(MAX_ENTRIES + 1);
  localparam int unsigned EW    = (IW > 6) ? IW : 6;
  localparam int unsigned AB    = (AMOUNT_BITS < 32) ? AMOUNT_BITS : 32;
  localparam int unsigned AW    = RegionW + IW;
  localparam int unsigned DEPTH = NumRegions * (1 << IW);

  localparam logic [4:0] S_IDLE    = 5'd0;
  localparam logic [4:0] S_RESP    = 5'd1;
  localparam logic [4:0] S_RDW     = 5'd2;
  localparam logic [4:0] S_SW1     = 5'd3;
  localparam logic [4:0] S_SW2     = 5'd4;
  localparam logic [4:0] S_SW3     = 5'd5;
  localparam logic [4:0] S_DIV     = 5'd6;
  localparam logic [4:0] S_NEXT    = 5'd7;
  localparam logic [4:0] S_P_FILL  = 5'd8;
  localparam logic [4:0] S_P_RD1   = 5'd9;
  localparam logic [4:0] S_P_RD1W  = 5'd10;
  localparam logic [4:0] S_P_MOD   = 5'd11;
  localparam logic [4:0] S_P_RD2W  = 5'd12;
  localparam logic [4:0] S_C_CLR   = 5'd13;
  localparam logic [4:0] S_C_SCAN  = 5'd14;
  localparam logic [4:0] S_C_SCANW = 5'd15;
  localparam logic [4:0] S_C_WALK  = 5'd16;
  localparam logic [4:0] S_C_WALK1 = 5'd17;
  localparam logic [4:0] S_C_WALK2 = 5'd18;
  localparam logic [4:0] S_C_WALK3 = 5'd19;
  localparam logic [4:0] S_C_FIN   = 5'd20;

  logic [CfgW-1:0] cfg_q;
  logic [31:0]     cfg_ext;
  logic [31:0]     n_full;
  logic [NW-1:0]   n_w;

  assign cfg_ext = 32'(cfg_q);
  assign n_full  = (cfg_ext == 32'd0) ? 32'd1 :
                   (cfg_ext > MAX_ENTRIES) ? 32'(MAX_ENTRIES) : cfg_ext;
  assign n_w     = NW'(n_full);

  // table memory
  logic [EW-1:0] mem [DEPTH];
  logic          mem_we, mem_re;
  logic [AW-1:0] mem_waddr, mem_raddr;
  logic [EW-1:0] mem_wdata, rdata_q;

  always_ff @(posedge clk_i) begin
    if (mem_we) mem[mem_waddr] <= mem_wdata;
    if (mem_re) rdata_q <= mem[mem_raddr];
  end

  // visited flags
  logic          vis_mem [MAX_ENTRIES];
  logic          vis_we, vis_re, vis_wdata, vis_q;
  logic [IW-1:0] vis_waddr, vis_raddr;

  always_ff @(posedge clk_i) begin
    if (vis_we) vis_mem[vis_waddr] <= vis_wdata;
    if (vis_re) vis_q <= vis_mem[vis_raddr];
  end

  // residue table for stored values below 64
  logic [5:0] tab_mem [64];
  logic       tab_busy_q, tab_re;
  logic [5:0] tab_cnt_q, tab_r_q, tab_raddr, tab_q;
  logic [31:0] tab_r_inc;

  assign tab_r_inc = 32'(tab_r_q) + 32'd1;

  always_ff @(posedge clk_i) begin
    if (tab_busy_q) tab_mem[tab_cnt_q] <= tab_r_q;
    if (tab_re) tab_q <= tab_mem[tab_raddr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q      <= CfgW'(64);
      tab_busy_q <= 1'b1;
      tab_cnt_q  <= '0;
      tab_r_q    <= '0;
    end else if (cfg_we_i) begin
      cfg_q      <= cfg_wdata_i;
      tab_busy_q <= 1'b1;
      tab_cnt_q  <= '0;
      tab_r_q    <= '0;
    end else if (tab_busy_q) begin
      tab_cnt_q <= tab_cnt_q + 6'd1;
      tab_r_q   <= (tab_r_inc == n_full) ? 6'd0 : tab_r_inc[5:0];
      if (tab_cnt_q == 6'd63) tab_busy_q <= 1'b0;
    end
  end

  logic [EW-1:0] modval;
  assign modval = (32'(rdata_q) > 32'd63) ? rdata_q : EW'(tab_q);

  // residue divider for rotation distance
  logic          div_start, div_busy;
  logic [NW-1:0] div_rem;

  ptab_mod_unit #(.DW(AB), .NW(NW)) u_mod (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (req_i.amount[AB-1:0]),
    .divisor_i  (n_w),
    .busy_o     (div_busy),
    .rem_o      (div_rem)
  );

  // sequencer state
  logic [4:0]          state_q, state_d;
  logic [ReqTypeW-1:0] op_q, op_d;
  logic [2:0]          ph_q, ph_d;
  pass_e               pass_q, pass_d;
  logic [IW-1:0]       i_q, i_d, ptr_q, ptr_d;
  logic [NW-1:0]       len_q, len_d;
  logic [RegionW-1:0]  src_q, src_d, by_q, by_d, dst_q, dst_d;
  logic [IndexW-1:0]   ia_q, ia_d, ib_q, ib_d;
  logic [AB-1:0]       amt_q, amt_d;
  logic                st_q, st_d;
  logic [EW-1:0]       t_q, t_d;
  logic [IW-1:0]       nx_q, nx_d, s_q, s_d, cur_q, cur_d;
  logic [NW-1:0]       cyc_q, cyc_d;
  logic                pend_q, pend_d;
  logic [ValueW-1:0]   pend_val_q, pend_val_d;

  logic              out_vld_q, out_cend_q, out_last_q, out_st_q;
  logic [ValueW-1:0] out_val_q, out_tc_q;
  logic              emit, emit_cend, emit_last, emit_st;
  logic [ValueW-1:0] emit_val, emit_tc;
  logic              out_free, accept;
  logic              i_last, s_last, ptr_wrap;
  logic [IW-1:0]     j_idx;

  assign out_free    = !out_vld_q || rsp_o.ready;
  assign req_i.ready = (state_q == S_IDLE) && !tab_busy_q;
  assign accept      = req_i.valid && req_i.ready;
  assign i_last      = (32'(i_q) + 32'd1) == 32'(len_q);
  assign s_last      = (32'(s_q) + 32'd1) == n_full;
  assign ptr_wrap    = (32'(ptr_q) + 32'd1) == n_full;
  assign j_idx       = modval[IW-1:0];

  always_comb begin
    logic chk, sq;
    logic [AB-1:0] amt_sh;
    chk        = 1'b0;
    sq         = 1'b0;
    amt_sh     = amt_q >> 1;
    state_d    = state_q;
    op_d       = op_q;
    ph_d       = ph_q;
    pass_d     = pass_q;
    i_d        = i_q;
    ptr_d      = ptr_q;
    len_d      = len_q;
    src_d      = src_q;
    by_d       = by_q;
    dst_d      = dst_q;
    ia_d       = ia_q;
    ib_d       = ib_q;
    amt_d      = amt_q;
    st_d       = st_q;
    t_d        = t_q;
    nx_d       = nx_q;
    s_d        = s_q;
    cur_d      = cur_q;
    cyc_d      = cyc_q;
    pend_d     = pend_q;
    pend_val_d = pend_val_q;
    mem_we     = 1'b0;
    mem_waddr  = '0;
    mem_wdata  = '0;
    mem_re     = 1'b0;
    mem_raddr  = '0;
    vis_we     = 1'b0;
    vis_waddr  = '0;
    vis_wdata  = 1'b0;
    vis_re     = 1'b0;
    vis_raddr  = '0;
    tab_re     = 1'b0;
    tab_raddr  = rdata_q[5:0];
    div_start  = 1'b0;
    emit       = 1'b0;
    emit_val   = '0;
    emit_cend  = 1'b0;
    emit_last  = 1'b0;
    emit_tc    = '0;
    emit_st    = 1'b0;

    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          op_d  = req_i.req_type;
          ia_d  = req_i.index_a;
          ib_d  = req_i.index_b;
          amt_d = req_i.amount[AB-1:0];
          st_d  = 1'b0;
          ph_d  = '0;
          i_d   = '0;
          len_d = n_w;
          unique case (req_i.req_type)
            OP_READ: begin
              if (32'(req_i.index_a) >= n_full) begin
                st_d    = 1'b1;
                state_d = S_RESP;
              end else begin
                mem_re    = 1'b1;
                mem_raddr = {RG_WORK, IW'(req_i.index_a)};
                state_d   = S_RDW;
              end
            end
            OP_WR_WORK, OP_WR_OPND: begin
              if (32'(req_i.index_a) >= n_full) begin
                st_d = 1'b1;
              end else begin
                mem_we    = 1'b1;
                mem_waddr = {(req_i.req_type == OP_WR_WORK) ? RG_WORK : RG_OPND,
                             IW'(req_i.index_a)};
                mem_wdata = EW'(req_i.entry_value);
              end
              state_d = S_RESP;
            end
            OP_IDENTITY: begin
              pass_d  = PS_FILL;
              dst_d   = RG_WORK;
              len_d   = NW'(MAX_ENTRIES);
              state_d = S_P_FILL;
            end
            OP_SWAP: begin
              if (32'(req_i.index_a) >= n_full || 32'(req_i.index_b) >= n_full) begin
                st_d    = 1'b1;
                state_d = S_RESP;
              end else begin
                mem_re    = 1'b1;
                mem_raddr = {RG_WORK, IW'(req_i.index_a)};
                state_d   = S_SW1;
              end
            end
            OP_ROT_UP, OP_ROT_DOWN: begin
              div_start = 1'b1;
              state_d   = S_DIV;
            end
            OP_INVERT: begin
              pass_d  = PS_FILL;
              dst_d   = RG_SCRATCH;
              state_d = S_P_FILL;
            end
            OP_COMPOSE: begin
              pass_d  = PS_COMP;
              src_d   = RG_WORK;
              by_d    = RG_OPND;
              dst_d   = RG_SCRATCH;
              state_d = S_P_RD1;
            end
            OP_POWER: begin
              pass_d  = PS_COPY;
              src_d   = RG_WORK;
              dst_d   = RG_BASE;
              state_d = S_P_RD1;
            end
            OP_CYCLES: begin
              state_d = S_C_CLR;
            end
            default: begin
              state_d = S_RESP;
            end
          endcase
        end
      end
      S_RESP: begin
        if (out_free) begin
          emit      = 1'b1;
          emit_last = 1'b1;
          emit_st   = st_q;
          state_d   = S_IDLE;
        end
      end
      S_RDW: begin
        if (out_free) begin
          emit      = 1'b1;
          emit_val  = rdata_q[ValueW-1:0];
          emit_last = 1'b1;
          state_d   = S_IDLE;
        end
      end
      S_SW1: begin
        t_d       = rdata_q;
        mem_re    = 1'b1;
        mem_raddr = {RG_WORK, IW'(ib_q)};
        state_d   = S_SW2;
      end
      S_SW2: begin
        mem_we    = 1'b1;
        mem_waddr = {RG_WORK, IW'(ia_q)};
        mem_wdata = rdata_q;
        state_d   = S_SW3;
      end
      S_SW3: begin
        mem_we    = 1'b1;
        mem_waddr = {RG_WORK, IW'(ib_q)};
        mem_wdata = t_q;
        state_d   = S_RESP;
      end
      S_DIV: begin
        if (!div_busy) begin
          if (op_q == OP_ROT_UP) begin
            ptr_d = (div_rem == '0) ? '0 : IW'(n_w - div_rem);
          end else begin
            ptr_d = IW'(div_rem);
          end
          pass_d  = PS_ROT;
          dst_d   = RG_SCRATCH;
          i_d     = '0;
          len_d   = n_w;
          ph_d    = '0;
          state_d = S_P_RD1;
        end
      end
      S_P_FILL: begin
        mem_we    = 1'b1;
        mem_waddr = {dst_q, i_q};
        mem_wdata = EW'(i_q);
        if (i_last) state_d = S_NEXT;
        else i_d = i_q + IW'(1);
      end
      S_P_RD1: begin
        mem_re = 1'b1;
        unique case (pass_q)
          PS_COPY: mem_raddr = {src_q, i_q};
          PS_COMP: mem_raddr = {by_q, i_q};
          PS_ROT:  mem_raddr = {RG_WORK, ptr_q};
          default: mem_raddr = {RG_WORK, i_q};
        endcase
        state_d = S_P_RD1W;
      end
      S_P_RD1W: begin
        if (pass_q == PS_COMP || pass_q == PS_INV) begin
          tab_re  = 1'b1;
          state_d = S_P_MOD;
        end else begin
          mem_we    = 1'b1;
          mem_waddr = {dst_q, i_q};
          mem_wdata = rdata_q;
          ptr_d     = ptr_wrap ? '0 : ptr_q + IW'(1);
          if (i_last) state_d = S_NEXT;
          else begin
            i_d     = i_q + IW'(1);
            state_d = S_P_RD1;
          end
        end
      end
      S_P_MOD: begin
        if (pass_q == PS_COMP) begin
          mem_re    = 1'b1;
          mem_raddr = {src_q, j_idx};
          state_d   = S_P_RD2W;
        end else begin
          mem_we    = 1'b1;
          mem_waddr = {dst_q, j_idx};
          mem_wdata = EW'(i_q);
          if (i_last) state_d = S_NEXT;
          else begin
            i_d     = i_q + IW'(1);
            state_d = S_P_RD1;
          end
        end
      end
      S_P_RD2W: begin
        mem_we    = 1'b1;
        mem_waddr = {dst_q, i_q};
        mem_wdata = rdata_q;
        if (i_last) state_d = S_NEXT;
        else begin
          i_d     = i_q + IW'(1);
          state_d = S_P_RD1;
        end
      end
      S_NEXT: begin
        i_d   = '0;
        len_d = n_w;
        ph_d  = ph_q + 3'd1;
        priority case (op_q)
          OP_INIT: begin
            if (ph_q == 3'd0) begin
              pass_d  = PS_FILL;
              dst_d   = RG_OPND;
              len_d   = NW'(MAX_ENTRIES);
              state_d = S_P_FILL;
            end else begin
              state_d = S_IDLE;
            end
          end
          OP_ROT_UP, OP_ROT_DOWN, OP_COMPOSE: begin
            if (ph_q == 3'd0) begin
              pass_d  = PS_COPY;
              src_d   = RG_SCRATCH;
              dst_d   = RG_WORK;
              state_d = S_P_RD1;
            end else begin
              state_d = S_RESP;
            end
          end
          OP_INVERT: begin
            if (ph_q == 3'd0) begin
              pass_d  = PS_INV;
              dst_d   = RG_SCRATCH;
              state_d = S_P_RD1;
            end else if (ph_q == 3'd1) begin
              pass_d  = PS_COPY;
              src_d   = RG_SCRATCH;
              dst_d   = RG_WORK;
              state_d = S_P_RD1;
            end else begin
              state_d = S_RESP;
            end
          end
          OP_POWER: begin
            unique case (ph_q)
              3'd0: begin
                pass_d  = PS_FILL;
                dst_d   = RG_ACCUM;
                state_d = S_P_FILL;
              end
              3'd1, 3'd5: chk = 1'b1;
              3'd2: begin
                pass_d  = PS_COPY;
                src_d   = RG_SCRATCH;
                dst_d   = RG_ACCUM;
                state_d = S_P_RD1;
              end
              3'd3: sq = 1'b1;
              3'd4: begin
                pass_d  = PS_COPY;
                src_d   = RG_SCRATCH;
                dst_d   = RG_BASE;
                state_d = S_P_RD1;
              end
              default: state_d = S_RESP;
            endcase
            if (chk) begin
              if (amt_q == '0) begin
                ph_d    = 3'd6;
                pass_d  = PS_COPY;
                src_d   = RG_ACCUM;
                dst_d   = RG_WORK;
                state_d = S_P_RD1;
              end else if (amt_q[0]) begin
                ph_d    = 3'd2;
                pass_d  = PS_COMP;
                src_d   = RG_ACCUM;
                by_d    = RG_BASE;
                dst_d   = RG_SCRATCH;
                state_d = S_P_RD1;
              end else begin
                sq = 1'b1;
              end
            end
            if (sq) begin
              amt_d   = amt_sh;
              pass_d  = (amt_sh != '0) ? PS_COMP : PS_COPY;
              ph_d    = (amt_sh != '0) ? 3'd4 : 3'd6;
              src_d   = (amt_sh != '0) ? RG_BASE : RG_ACCUM;
              by_d    = RG_BASE;
              dst_d   = (amt_sh != '0) ? RG_SCRATCH : RG_WORK;
              state_d = S_P_RD1;
            end
          end
          default: state_d = S_RESP;
        endcase
      end
      S_C_CLR: begin
        vis_we    = 1'b1;
        vis_waddr = i_q;
        vis_wdata = 1'b0;
        if (i_last) begin
          s_d     = '0;
          cyc_d   = '0;
          pend_d  = 1'b0;
          state_d = S_C_SCAN;
        end else begin
          i_d = i_q + IW'(1);
        end
      end
      S_C_SCAN: begin
        vis_re    = 1'b1;
        vis_raddr = s_q;
        state_d   = S_C_SCANW;
      end
      S_C_SCANW: begin
        if (vis_q) begin
          if (s_last) state_d = S_C_FIN;
          else begin
            s_d     = s_q + IW'(1);
            state_d = S_C_SCAN;
          end
        end else if (!pend_q || out_free) begin
          if (pend_q) begin
            emit      = 1'b1;
            emit_val  = pend_val_q;
            emit_cend = 1'b1;
          end
          pend_d    = 1'b0;
          vis_we    = 1'b1;
          vis_waddr = s_q;
          vis_wdata = 1'b1;
          cur_d     = s_q;
          cyc_d     = cyc_q + NW'(1);
          state_d   = S_C_WALK;
        end
      end
      S_C_WALK: begin
        mem_re    = 1'b1;
        mem_raddr = {RG_WORK, cur_q};
        state_d   = S_C_WALK1;
      end
      S_C_WALK1: begin
        tab_re  = 1'b1;
        state_d = S_C_WALK2;
      end
      S_C_WALK2: begin
        nx_d      = j_idx;
        vis_re    = 1'b1;
        vis_raddr = j_idx;
        state_d   = S_C_WALK3;
      end
      S_C_WALK3: begin
        if (nx_q == s_q || vis_q) begin
          pend_d     = 1'b1;
          pend_val_d = rdata_q[ValueW-1:0];
          if (s_last) state_d = S_C_FIN;
          else begin
            s_d     = s_q + IW'(1);
            state_d = S_C_SCAN;
          end
        end else if (out_free) begin
          emit      = 1'b1;
          emit_val  = rdata_q[ValueW-1:0];
          vis_we    = 1'b1;
          vis_waddr = nx_q;
          vis_wdata = 1'b1;
          cur_d     = nx_q;
          state_d   = S_C_WALK;
        end
      end
      S_C_FIN: begin
        if (out_free) begin
          emit      = 1'b1;
          emit_val  = pend_val_q;
          emit_cend = 1'b1;
          emit_last = 1'b1;
          emit_tc   = ValueW'(n_w - cyc_q);
          pend_d    = 1'b0;
          state_d   = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_P_FILL;
      op_q      <= OP_INIT;
      ph_q      <= '0;
      pass_q    <= PS_FILL;
      i_q       <= '0;
      len_q     <= NW'(MAX_ENTRIES);
      dst_q     <= RG_WORK;
      src_q     <= RG_WORK;
      by_q      <= RG_OPND;
      pend_q    <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      state_q <= state_d;
      op_q    <= op_d;
      ph_q    <= ph_d;
      pass_q  <= pass_d;
      i_q     <= i_d;
      len_q   <= len_d;
      dst_q   <= dst_d;
      src_q   <= src_d;
      by_q    <= by_d;
      pend_q  <= pend_d;
      if (emit) out_vld_q <= 1'b1;
      else if (rsp_o.ready) out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    ptr_q      <= ptr_d;
    ia_q       <= ia_d;
    ib_q       <= ib_d;
    amt_q      <= amt_d;
    st_q       <= st_d;
    t_q        <= t_d;
    nx_q       <= nx_d;
    s_q        <= s_d;
    cur_q      <= cur_d;
    cyc_q      <= cyc_d;
    pend_val_q <= pend_val_d;
    if (emit) begin
      out_val_q  <= emit_val;
      out_cend_q <= emit_cend;
      out_last_q <= emit_last;
      out_tc_q   <= emit_tc;
      out_st_q   <= emit_st;
    end
  end

  assign rsp_o.valid        = out_vld_q;
  assign rsp_o.result_value = out_val_q;
  assign rsp_o.cycle_end    = out_cend_q;
  assign rsp_o.last         = out_last_q;
  assign rsp_o.transp_cnt   = out_tc_q;
  assign rsp_o.status       = out_st_q;

  a_no_accept_while_table_builds: assert property (
    @(posedge clk_i) disable iff (!rst_ni) tab_busy_q |-> !req_i.ready)
    else $error("request taken while residue table is rebuilt");

  a_cycle_count_bounded: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_C_WALK3) |-> (32'(cyc_q) <= n_full))
    else $error("cycle count exceeds table size");

  a_write_region_valid: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    mem_we |-> (32'(mem_waddr[AW-1:IW]) < NumRegions))
    else $error("table write outside defined regions");

  a_emit_only_when_free: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    (out_vld_q && !rsp_o.ready) |-> !emit)
    else $error("result overwritten while stalled");
endmodule
